/* hdl/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted while reset is high.
`define ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, muted while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* hdl/swrs_pkg.sv */
`timescale 1ns / 1ps
package swrs_pkg;

  localparam int KEY_W = 64;
  localparam int TAG_W = 32;

  // operation codes
  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_REMOVE   = 2'd1;
  localparam logic [1:0] OP_MIN_RANK = 2'd2;
  localparam logic [1:0] OP_GET      = 2'd3;

  localparam logic [KEY_W-1:0] SIGN_BIT = {1'b1, {(KEY_W-1){1'b0}}};

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic cmp_en;    // register compare flags
    logic le_mode;   // flag means "<= query" rather than "< query"
    logic get_mode;  // leaf marks the addressed cell instead of the boundary
    logic ins_en;    // shift up and drop the new item in
    logic rem_en;    // shift down over the removed entry
  } cell_ctrl_t;

  // Map a double bit pattern onto an unsigned value of the same order;
  // negative zero folds onto positive zero.
  function automatic logic [KEY_W-1:0] order_of(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] z;
    z = (k == SIGN_BIT) ? '0 : k;
    if (z[KEY_W-1]) begin
      return ~z;
    end
    return z | SIGN_BIT;
  endfunction

endpackage

/* hdl/swrs_cell.sv */
`timescale 1ns / 1ps
module swrs_cell import swrs_pkg::*; #(
  parameter int INDEX = 0,
  parameter int CW    = 9
) (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [KEY_W-1:0] query_ord,
  input  logic [7:0]       rank,
  input  logic [CW-1:0]    count,
  input  logic [KEY_W-1:0] ins_key,
  input  logic [TAG_W-1:0] ins_tag,
  input  logic             prev_flag,
  input  logic [KEY_W-1:0] prev_key,
  input  logic [TAG_W-1:0] prev_tag,
  input  logic [KEY_W-1:0] next_key,
  input  logic [TAG_W-1:0] next_tag,
  output logic [KEY_W-1:0] key,
  output logic [TAG_W-1:0] tag,
  output logic             flag,
  output logic             leaf_valid
);

  localparam int RW = (CW > 8) ? CW : 8;
  localparam logic [RW-1:0] IDX = RW'(INDEX);

  logic [KEY_W-1:0] own_ord;
  logic             occ;
  logic             below;
  logic             sel;

  // local compare against the broadcast query
  assign own_ord = order_of(key);
  assign occ     = IDX < RW'(count);
  assign below   = ctrl.le_mode ? (own_ord <= query_ord) : (own_ord < query_ord);

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      flag <= occ && below;
      sel  <= occ && (RW'(rank) == IDX);
    end
  end

  // boundary cell (first unflagged) or addressed cell feeds the tree
  assign leaf_valid = ctrl.get_mode ? sel : !flag;

  // shift with the neighbours; flags form a thermometer along the row
  always_ff @(posedge clk) begin
    if (ctrl.ins_en && !flag) begin
      key <= prev_flag ? ins_key : prev_key;
      tag <= prev_flag ? ins_tag : prev_tag;
    end else if (ctrl.rem_en && !flag) begin
      key <= next_key;
      tag <= next_tag;
    end
  end

endmodule

/* hdl/swrs_tree.sv */
`timescale 1ns / 1ps
module swrs_tree #(
  parameter int N  = 256,
  parameter int LW = 8,
  parameter int DW = 96
) (
  input  logic          clk,
  input  logic          leaf_valid [N],
  input  logic [DW-1:0] leaf_data  [N],
  output logic          root_valid,
  output logic [LW-1:0] root_index,
  output logic [DW-1:0] root_data
);

  localparam int LEAVES = 1 << LW;

  logic          lv [LEAVES];
  logic [DW-1:0] ld [LEAVES];
  logic          nv [1:LEAVES-1];
  logic [LW-1:0] ni [1:LEAVES-1];
  logic [DW-1:0] nd [1:LEAVES-1];

  // pad the leaf row up to a power of two
  for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
    if (j < N) begin : g_real
      assign lv[j] = leaf_valid[j];
      assign ld[j] = leaf_data[j];
    end else begin : g_pad
      assign lv[j] = 1'b0;
      assign ld[j] = '0;
    end
  end

  // registered priority tree, lowest index wins, one level per cycle
  for (genvar n = 1; n < LEAVES; n++) begin : g_node
    if (2 * n >= LEAVES) begin : g_bottom
      localparam int L = 2 * n - LEAVES;
      always_ff @(posedge clk) begin
        if (lv[L]) begin
          nv[n] <= 1'b1;
          ni[n] <= LW'(L);
          nd[n] <= ld[L];
        end else begin
          nv[n] <= lv[L+1];
          ni[n] <= LW'(L + 1);
          nd[n] <= ld[L+1];
        end
      end
    end else begin : g_inner
      always_ff @(posedge clk) begin
        if (nv[2*n]) begin
          nv[n] <= 1'b1;
          ni[n] <= ni[2*n];
          nd[n] <= nd[2*n];
        end else begin
          nv[n] <= nv[2*n+1];
          ni[n] <= ni[2*n+1];
          nd[n] <= nd[2*n+1];
        end
      end
    end
  end

  assign root_valid = nv[1];
  assign root_index = ni[1];
  assign root_data  = nd[1];

endmodule

/* hdl/sorted_window_rank_store.sv */
`timescale 1ns / 1ps
// Channel  | Handshake      | Payload
// command  | start / busy   | op, key, tag_in, rank_in
// result   | done (strobe)  | rank_out, found, key_out, tag_out, count, full_error
//
// An item is taken when start is high and busy is low. Busy then stays high through
// the compare state in the cell row, the tree state while the registered priority
// tree resolves one level per cycle, and the apply state. The result shows for one
// cycle with done, busy already low, so a new item may be taken in that cycle. The
// receiver cannot stall. Synchronous reset empties the store at once; cell contents
// are not cleared.
module sorted_window_rank_store import swrs_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       op,
  input  logic [KEY_W-1:0] key,
  input  logic [TAG_W-1:0] tag_in,
  input  logic [7:0]       rank_in,
  output logic             done,
  output logic [8:0]       rank_out,
  output logic             found,
  output logic [KEY_W-1:0] key_out,
  output logic [TAG_W-1:0] tag_out,
  output logic [8:0]       count,
  output logic             full_error
);

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int LW     = $clog2(CAPACITY);
  localparam int SW     = $clog2(LW + 1);
  localparam int XW     = (CW > LW + 1) ? CW : LW + 1;
  localparam int DW     = KEY_W + TAG_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CMP   = 2'd1;
  localparam logic [1:0] ST_TREE  = 2'd2;
  localparam logic [1:0] ST_APPLY = 2'd3;

  logic [1:0]       state;
  logic [SW-1:0]    wait_cnt;
  logic [CW-1:0]    held_count;
  logic [CW-1:0]    held_count_next;

  logic [1:0]       cmd_op;
  logic [KEY_W-1:0] cmd_key;
  logic [TAG_W-1:0] cmd_tag;
  logic [7:0]       cmd_rank;

  logic [KEY_W-1:0] query_ord;
  logic             full;
  logic             hit;
  logic [XW-1:0]    pos_rank;
  cell_ctrl_t       ctrl;

  logic [KEY_W-1:0] cell_key   [CAPACITY];
  logic [TAG_W-1:0] cell_tag   [CAPACITY];
  logic             cell_flag  [CAPACITY];
  logic             leaf_valid [CAPACITY];
  logic [DW-1:0]    leaf_data  [CAPACITY];
  logic             prv_flag   [CAPACITY];
  logic [KEY_W-1:0] prv_key    [CAPACITY];
  logic [TAG_W-1:0] prv_tag    [CAPACITY];
  logic [KEY_W-1:0] nxt_key    [CAPACITY];
  logic [TAG_W-1:0] nxt_tag    [CAPACITY];

  logic             root_valid;
  logic [LW-1:0]    root_index;
  logic [DW-1:0]    root_data;
  logic [KEY_W-1:0] root_key;
  logic [TAG_W-1:0] root_tag;

  assign busy      = (state != ST_IDLE);
  assign query_ord = order_of(cmd_key);
  assign full      = (held_count == CW'(CAPACITY));

  // broadcast control
  always_comb begin
    ctrl.cmp_en   = (state == ST_CMP);
    ctrl.le_mode  = (cmd_op == OP_INSERT);
    ctrl.get_mode = (cmd_op == OP_GET);
    ctrl.ins_en   = (state == ST_APPLY) && (cmd_op == OP_INSERT) && !full;
    ctrl.rem_en   = (state == ST_APPLY) && (cmd_op == OP_REMOVE) && hit;
  end

  // cell row with neighbour links
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prv_flag[i] = 1'b1;
      assign prv_key[i]  = cmd_key;
      assign prv_tag[i]  = cmd_tag;
    end else begin : g_mid
      assign prv_flag[i] = cell_flag[i-1];
      assign prv_key[i]  = cell_key[i-1];
      assign prv_tag[i]  = cell_tag[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign nxt_key[i] = cell_key[i];
      assign nxt_tag[i] = cell_tag[i];
    end else begin : g_inner
      assign nxt_key[i] = cell_key[i+1];
      assign nxt_tag[i] = cell_tag[i+1];
    end

    swrs_cell #(
      .INDEX (i),
      .CW    (CW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .query_ord  (query_ord),
      .rank       (cmd_rank),
      .count      (held_count),
      .ins_key    (cmd_key),
      .ins_tag    (cmd_tag),
      .prev_flag  (prv_flag[i]),
      .prev_key   (prv_key[i]),
      .prev_tag   (prv_tag[i]),
      .next_key   (nxt_key[i]),
      .next_tag   (nxt_tag[i]),
      .key        (cell_key[i]),
      .tag        (cell_tag[i]),
      .flag       (cell_flag[i]),
      .leaf_valid (leaf_valid[i])
    );

    assign leaf_data[i] = {cell_key[i], cell_tag[i]};
  end

  // finds the boundary cell or the addressed cell
  swrs_tree #(
    .N  (CAPACITY),
    .LW (LW),
    .DW (DW)
  ) u_tree (
    .clk        (clk),
    .leaf_valid (leaf_valid),
    .leaf_data  (leaf_data),
    .root_valid (root_valid),
    .root_index (root_index),
    .root_data  (root_data)
  );

  assign root_key = root_data[DW-1:TAG_W];
  assign root_tag = root_data[TAG_W-1:0];

  // no boundary found means every cell is held and below the query
  assign pos_rank = root_valid ? XW'(root_index) : XW'(CAPACITY);
  assign hit      = root_valid && (XW'(root_index) < XW'(held_count)) &&
                    (order_of(root_key) == query_ord);

  // fill level after the current item
  always_comb begin
    held_count_next = held_count;
    if (cmd_op == OP_INSERT && !full) begin
      held_count_next = held_count + 1'b1;
    end else if (cmd_op == OP_REMOVE && hit) begin
      held_count_next = held_count - 1'b1;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      wait_cnt   <= '0;
      held_count <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          wait_cnt <= '0;
          state    <= ST_TREE;
        end
        ST_TREE: begin
          if (wait_cnt == SW'(LW - 1)) begin
            state <= ST_APPLY;
          end else begin
            wait_cnt <= wait_cnt + 1'b1;
          end
        end
        ST_APPLY: begin
          held_count <= held_count_next;
          done       <= 1'b1;
          state      <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // command capture
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_op   <= op;
      cmd_key  <= key;
      cmd_tag  <= tag_in;
      cmd_rank <= rank_in;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (state == ST_APPLY) begin
      rank_out   <= '0;
      found      <= 1'b0;
      key_out    <= '0;
      tag_out    <= '0;
      full_error <= 1'b0;
      count      <= 9'(held_count_next);
      case (cmd_op)
        OP_INSERT: begin
          if (full) begin
            full_error <= 1'b1;
          end else begin
            rank_out <= 9'(pos_rank);
          end
        end
        OP_REMOVE: begin
          found <= hit;
        end
        OP_MIN_RANK: begin
          rank_out <= 9'(pos_rank);
        end
        OP_GET: begin
          found <= root_valid;
          if (root_valid) begin
            key_out <= root_key;
            tag_out <= root_tag;
          end
        end
        default: begin
          found <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* hdl/swrs_check.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module swrs_check (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [8:0] rank_out,
  input logic       found,
  input logic       full_error
);

  // an accepted item keeps the block busy in the following cycle
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  // the result appears only once the block has gone idle
  `ASSERT_NOW(a_done_idle, clk, rst, done, !busy)
  // one result per item, never back to back
  `ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  // a refused insert reports nothing else
  `ASSERT_NOW(a_full_clean, clk, rst, done && full_error, !found && rank_out == 9'd0)

endmodule

bind sorted_window_rank_store swrs_check u_check (.*);
